FILE: rtl/ntc_thermistor_temperature_top_assert.svh
// ----------------------------------------------------------------------------
// NTC thermistor assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef NTC_THERMISTOR_TEMPERATURE_TOP_ASSERT_SVH
`define NTC_THERMISTOR_TEMPERATURE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ntc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ntc assertion failed");

`endif

FILE: rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC thermistor package
// Shared types, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam logic [2:0] CFG_ALPHA  = 3'd0;
  localparam logic [2:0] CFG_REF    = 3'd1;
  localparam logic [2:0] CFG_COEF_A = 3'd2;
  localparam logic [2:0] CFG_COEF_B = 3'd3;
  localparam logic [2:0] CFG_COEF_C = 3'd4;
  localparam logic [2:0] CFG_OFFSET = 3'd5;
  localparam logic [2:0] CFG_PERIOD = 3'd6;

  localparam logic [63:0] LN2_Q32    = 64'd2977044472;
  localparam logic [63:0] KELVIN_Q8  = 64'd699264;
  localparam logic [63:0] TEN_Q56    = 64'd10 << 56;
  localparam logic [15:0] TEMP_SAT   = 16'h7FFF;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } op_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RES_MUL, ST_RES_DIV, ST_EMA_MUL1, ST_EMA_MUL2, ST_CHECK,
    ST_NORM, ST_LOG_SQ, ST_LOG_FRAC, ST_LOG_EXP, ST_SH_L2, ST_SH_L3,
    ST_SH_BL, ST_SH_CL, ST_SH_SUM, ST_TEMP_DIV, ST_TEMP_FIN, ST_TEMP_SAT,
    ST_DONE
  } state_e;

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] mulq_fix(input logic [127:0] p,
                                                  input logic neg);
    logic [62:0] m;
    m = (|p[127:95]) ? {63{1'b1}} : p[94:32];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return $signed(s[63:0]);
  endfunction

endpackage

FILE: rtl/ntc_mul.sv
// ----------------------------------------------------------------------------
// NTC shared multiplier
// Unsigned 64 x 64 product built from four 32 x 32 partial products.
// ----------------------------------------------------------------------------
module ntc_mul import ntc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  op_req_t        req_i,
  output logic           done_o,
  output logic [127:0]   prod_o
);

  logic         busy_q, pv_q, done_q;
  logic [2:0]   cnt_q;
  logic [63:0]  a_q, b_q, pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [31:0]  a_half, b_half;

  assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        pv_q  <= ~cnt_q[2];
        if (cnt_q[2]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (!cnt_q[2]) begin
        pp_q <= 64'(a_half) * 64'(b_half);
        sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (pv_q) begin
        acc_q <= acc_q + (128'(pp_q) << {sh_q, 5'd0});
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: rtl/ntc_div.sv
// ----------------------------------------------------------------------------
// NTC serial divider
// Unsigned 64 / 64 restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_div import ntc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_req_t     req_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [64:0] rem_q, rem_sh;
  logic [63:0] q_q, dvs_q;
  logic        fits;

  assign rem_sh = {rem_q[63:0], q_q[63]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      q_q   <= req_i.a;
      dvs_q <= req_i.b;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      q_q   <= {q_q[62:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

FILE: rtl/ntc_thermistor_temperature_top.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature
// Divider sample to filtered resistance and Steinhart-Hart temperature.
// ----------------------------------------------------------------------------
// One word is taken at a time and its result word is held in an output
// register, so a new word is accepted while a result waits. A word without
// a report makes three passes through the shared multiplier, each of four
// 32 x 32 partial products, and one pass through the bit-serial divider,
// then the check, the output load and the return to idle. A report adds
// the normalisation shifts, 32 squarings and six further multiplies, one
// more divide unless the denominator is zero, and the sum, the offset and
// the rounding. A rejected sample without a report goes straight to the
// check, the output load and the return to idle. A result waits in the
// done state until the previous result word has left the output
// register.
`include "ntc_thermistor_temperature_top_assert.svh"

module ntc_thermistor_temperature_top import ntc_pkg::*; #(
  parameter int ADC_BITS      = 12,
  parameter int EMA_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // adc_sample [11:0], elapsed_ms [21:12]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // filtered_resistance [39:0], temperature_tenths [55:40]
  output logic [55:0] m_axis_tdata,
  // sample_rejected [0], temperature_valid [1]
  output logic [1:0]  m_axis_tuser
);

  localparam logic [15:0] MaxCode = 16'((32'd1 << ADC_BITS) - 1);
  localparam int          ExpTop  = 39 - EMA_FRAC_BITS;

  state_e state_q, state_d;
  logic   issued_q, issued_d, mul_go, div_go;

  logic [15:0] alpha_q, period_q;
  logic [19:0] ref_q;
  logic signed [63:0] ca_q, cb_q, cc_q;
  logic [10:0] off_q;

  logic [15:0] adc_q, adc_in;
  logic        rej_q, valid_q, rej_in, in_acc, out_free, report;
  logic [39:0] ema_q, r_q, v_q;
  logic [16:0] acc_q;
  logic [15:0] temp_q;
  logic [63:0] t_q;
  logic signed [63:0] l_q, l3_q, d_q;
  logic [31:0] y_q, frac_q;
  logic [5:0]  sh_q;
  logic [4:0]  cnt_q;
  logic signed [6:0] ex_q;

  logic        m_valid_q;
  logic [55:0] m_data_q;
  logic [1:0]  m_user_q;

  op_req_t      mul_req, div_req;
  logic         mul_done, div_done, mul_neg;
  logic [127:0] mul_prod;
  logic [63:0]  div_quot, ema_sum, mul_a, mul_b, exp_mag;
  logic [32:0]  sq;
  logic signed [63:0] tr;

  assign adc_in   = {4'd0, s_axis_tdata[11:0]} & MaxCode;
  assign rej_in   = (adc_in == '0) || (adc_in == MaxCode);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign report   = acc_q >= 17'(period_q);
  assign ema_sum  = t_q + mul_prod[63:0] + 64'd32768;
  assign sq       = mul_prod[63:31];
  assign exp_mag  = 64'(ex_q[6] ? 7'(-ex_q) : ex_q);
  assign tr       = $signed(t_q) < 0 ? ($signed(t_q) + 64'sd255) >>> 8 : $signed(t_q) >>> 8;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_q)
      ST_RES_MUL:  begin mul_a = 64'(ref_q);   mul_b = 64'(MaxCode - adc_q); end
      ST_EMA_MUL1: begin mul_a = 64'(alpha_q); mul_b = 64'(r_q); end
      ST_EMA_MUL2: begin mul_a = 64'(17'h10000 - 17'(alpha_q)); mul_b = 64'(ema_q); end
      ST_LOG_SQ:   begin mul_a = 64'(y_q);     mul_b = 64'(y_q); end
      ST_LOG_FRAC: begin mul_a = 64'(frac_q);  mul_b = LN2_Q32; end
      ST_LOG_EXP:  begin mul_a = exp_mag;      mul_b = LN2_Q32; end
      ST_SH_L2: begin
        mul_a = abs64(l_q); mul_b = abs64(l_q); mul_neg = 1'b0;
      end
      ST_SH_L3: begin
        mul_a = abs64(t_q); mul_b = abs64(l_q); mul_neg = t_q[63] ^ l_q[63];
      end
      ST_SH_BL: begin
        mul_a = abs64(cb_q); mul_b = abs64(l_q); mul_neg = cb_q[63] ^ l_q[63];
      end
      ST_SH_CL: begin
        mul_a = abs64(cc_q); mul_b = abs64(l3_q); mul_neg = cc_q[63] ^ l3_q[63];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    mul_go   = 1'b0;
    div_go   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = rej_in ? ST_CHECK : ST_RES_MUL;
      end
      ST_RES_MUL, ST_EMA_MUL1, ST_EMA_MUL2, ST_LOG_SQ, ST_LOG_FRAC, ST_LOG_EXP,
      ST_SH_L2, ST_SH_L3, ST_SH_BL, ST_SH_CL: begin
        if (!issued_q) begin
          mul_go   = 1'b1;
          issued_d = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          case (state_q)
            ST_RES_MUL:  state_d = ST_RES_DIV;
            ST_EMA_MUL1: state_d = ST_EMA_MUL2;
            ST_EMA_MUL2: state_d = ST_CHECK;
            ST_LOG_SQ:   state_d = (&cnt_q) ? ST_LOG_FRAC : ST_LOG_SQ;
            ST_LOG_FRAC: state_d = ST_LOG_EXP;
            ST_LOG_EXP:  state_d = ST_SH_L2;
            ST_SH_L2:    state_d = ST_SH_L3;
            ST_SH_L3:    state_d = ST_SH_BL;
            ST_SH_BL:    state_d = ST_SH_CL;
            default:     state_d = ST_SH_SUM;
          endcase
        end
      end
      ST_RES_DIV: begin
        if (!issued_q) begin
          div_go   = 1'b1;
          issued_d = 1'b1;
        end else if (div_done) begin
          issued_d = 1'b0;
          state_d  = ST_EMA_MUL1;
        end
      end
      ST_CHECK: begin
        if (report && ema_q != '0) state_d = ST_NORM;
        else                       state_d = ST_DONE;
      end
      ST_NORM: begin
        if (v_q[39]) state_d = ST_LOG_SQ;
      end
      ST_SH_SUM: state_d = ST_TEMP_DIV;
      ST_TEMP_DIV: begin
        if (!issued_q) begin
          if (d_q == '0) begin
            state_d = ST_DONE;
          end else begin
            div_go   = 1'b1;
            issued_d = 1'b1;
          end
        end else if (div_done) begin
          issued_d = 1'b0;
          state_d  = ST_TEMP_FIN;
        end
      end
      ST_TEMP_FIN: state_d = ST_TEMP_SAT;
      ST_TEMP_SAT: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_req.start = mul_go;
    mul_req.a     = mul_a;
    mul_req.b     = mul_b;
    div_req.start = div_go;
    div_req.a     = (state_q == ST_RES_DIV) ? (t_q << EMA_FRAC_BITS) : TEN_Q56;
    div_req.b     = (state_q == ST_RES_DIV) ? 64'(adc_q) : abs64(d_q);
  end

  ntc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  ntc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= 16'd6554;
      ref_q     <= 20'd100000;
      ca_q      <= -64'sd21053833106;
      cb_q      <= 64'sd89363387260;
      cc_q      <= -64'sd46841719;
      off_q     <= '0;
      period_q  <= 16'd1000;
      ema_q     <= '0;
      acc_q     <= '0;
      temp_q    <= '0;
      adc_q     <= '0;
      rej_q     <= 1'b0;
      valid_q   <= 1'b0;
      r_q       <= '0;
      v_q       <= '0;
      t_q       <= '0;
      l_q       <= '0;
      l3_q      <= '0;
      d_q       <= '0;
      y_q       <= '0;
      frac_q    <= '0;
      sh_q      <= '0;
      cnt_q     <= '0;
      ex_q      <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ALPHA:  alpha_q  <= cfg_data_i[15:0];
          CFG_REF:    ref_q    <= cfg_data_i[19:0];
          CFG_COEF_A: ca_q     <= {{16{cfg_data_i[47]}}, cfg_data_i};
          CFG_COEF_B: cb_q     <= {{16{cfg_data_i[47]}}, cfg_data_i};
          CFG_COEF_C: cc_q     <= {{16{cfg_data_i[47]}}, cfg_data_i};
          CFG_OFFSET: off_q    <= cfg_data_i[10:0];
          CFG_PERIOD: period_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tready && state_q != ST_DONE) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            adc_q   <= adc_in;
            acc_q   <= acc_q + 17'(s_axis_tdata[21:12]);
            rej_q   <= rej_in;
            valid_q <= 1'b0;
          end
        end
        ST_RES_MUL: if (mul_done) t_q <= mul_prod[63:0];
        ST_RES_DIV: if (div_done) r_q <= (|div_quot[63:40]) ? '1 : div_quot[39:0];
        ST_EMA_MUL1: if (mul_done) t_q <= mul_prod[63:0];
        ST_EMA_MUL2: if (mul_done) ema_q <= ema_sum[55:16];
        ST_CHECK: begin
          if (report) begin
            acc_q   <= '0;
            valid_q <= 1'b1;
            v_q     <= ema_q;
            sh_q    <= '0;
            cnt_q   <= '0;
            frac_q  <= '0;
            if (ema_q == '0) temp_q <= TEMP_SAT;
          end
        end
        ST_NORM: begin
          if (!v_q[39]) begin
            v_q  <= {v_q[38:0], 1'b0};
            sh_q <= sh_q + 6'd1;
          end else begin
            y_q  <= v_q[39:8];
            ex_q <= 7'(ExpTop) - 7'(sh_q);
          end
        end
        ST_LOG_SQ: begin
          if (mul_done) begin
            y_q    <= sq[32] ? sq[32:1] : sq[31:0];
            frac_q <= {frac_q[30:0], sq[32]};
            cnt_q  <= cnt_q + 5'd1;
          end
        end
        ST_LOG_FRAC: if (mul_done) t_q <= {32'd0, mul_prod[63:32]};
        ST_LOG_EXP: begin
          if (mul_done) begin
            l_q <= (ex_q[6] ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]))
                   + $signed(t_q);
          end
        end
        ST_SH_L2: if (mul_done) t_q <= mulq_fix(mul_prod, mul_neg);
        ST_SH_L3: if (mul_done) l3_q <= mulq_fix(mul_prod, mul_neg);
        ST_SH_BL: if (mul_done) t_q <= mulq_fix(mul_prod, mul_neg);
        ST_SH_CL: begin
          if (!issued_q) d_q <= add_sat(ca_q, $signed(t_q));
          else if (mul_done) t_q <= mulq_fix(mul_prod, mul_neg);
        end
        ST_SH_SUM: d_q <= add_sat(d_q, $signed(t_q));
        ST_TEMP_DIV: begin
          if (!issued_q && d_q == '0) temp_q <= TEMP_SAT;
          else if (issued_q && div_done) t_q <= d_q[63] ? 64'(-div_quot) : div_quot;
        end
        ST_TEMP_FIN: t_q <= t_q - KELVIN_Q8 + {{45{off_q[10]}}, off_q, 8'd0};
        ST_TEMP_SAT: begin
          if (tr > 64'sd32767)       temp_q <= 16'h7FFF;
          else if (tr < -64'sd32768) temp_q <= 16'h8000;
          else                       temp_q <= tr[15:0];
        end
        ST_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {temp_q, ema_q};
            m_user_q  <= {valid_q, rej_q};
          end
        end
        default: ;
      endcase
    end
  end

  `NTC_ASSERT_NEXT(a_busy_after_accept, in_acc, state_q != ST_IDLE)
  `NTC_ASSERT_IMPL(a_reject_keeps_ema, state_q == ST_CHECK && rej_q, $stable(ema_q))
  `NTC_ASSERT_NEXT(a_report_clears_time, state_q == ST_CHECK && report,
                   acc_q == '0 && valid_q)

endmodule

FILE: tb/sv/ntc_thermistor_temperature_top_test.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature testbench
// Drives divider samples with random gaps and stalls, predicts the filtered
// resistance and Steinhart-Hart temperature of every word, and checks each
// result word field by field across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ntc_thermistor_temperature_top_test import ntc_pkg::*;;

  localparam int MAXCODE = 4095;
  localparam logic [63:0] RES_MAX = (64'd1 << 40) - 1;
  localparam logic [63:0] LN2_C = 64'd2977044472;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [39:0] resistance;
    logic        rejected;
    logic        temp_valid;
    logic [15:0] tenths;
  } thermo_result_t;

  class thermo_scoreboard;
    logic [63:0] alpha, ref_ohms, period;
    longint coef_a, coef_b, coef_c, offset;
    logic [63:0] ema, acc;
    longint last_temp;
    thermo_result_t pending[$];
    int errors;

    function void reset_state();
      alpha = 6554; ref_ohms = 100000; period = 1000;
      coef_a = -64'sd21053833106; coef_b = 64'sd89363387260;
      coef_c = -64'sd46841719; offset = 0;
      ema = 0; acc = 0; last_temp = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] v);
      case (idx)
        CFG_ALPHA:  alpha = v[15:0];
        CFG_REF:    ref_ohms = v[19:0];
        CFG_COEF_A: coef_a = longint'($signed(v));
        CFG_COEF_B: coef_b = longint'($signed(v));
        CFG_COEF_C: coef_c = longint'($signed(v));
        CFG_OFFSET: offset = longint'($signed(v[10:0]));
        CFG_PERIOD: period = v[15:0];
        default: ;
      endcase
    endfunction

    function longint qmul(longint a, longint b);
      logic neg;
      logic [127:0] p;
      logic [63:0] ua, ub;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = ({64'd0, ua} * {64'd0, ub}) >> 32;
      if (p[127:63] != 0) return neg ? -64'sh7FFFFFFFFFFFFFFF : 64'sh7FFFFFFFFFFFFFFF;
      return neg ? -longint'(p[62:0]) : longint'(p[62:0]);
    endfunction

    function longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
      if (s < -65'sh0_8000000000000000) return 64'sh8000000000000000;
      return longint'(s[63:0]);
    endfunction

    function longint log_q32(logic [63:0] v);
      int e;
      logic [63:0] y, frac;
      e = 63;
      frac = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      y = e <= 31 ? v << (31 - e) : v >> (e - 31);
      for (int i = 0; i < 32; i++) begin
        y = (y * y) >> 31;
        frac = frac << 1;
        if (y >= (64'd1 << 32)) begin
          y = y >> 1;
          frac[0] = 1'b1;
        end
      end
      return longint'(e - 8) * longint'(LN2_C) + longint'(({64'd0, frac} * LN2_C) >> 32);
    endfunction

    function longint temperature(logic [63:0] r);
      longint l, l3, d, q, t;
      if (r == 0) return 32767;
      l = log_q32(r);
      l3 = qmul(qmul(l, l), l);
      d = sat_add(coef_a, qmul(coef_b, l));
      d = sat_add(d, qmul(coef_c, l3));
      if (d == 0) return 32767;
      q = (64'sd10 <<< 56) / d;
      t = (q - 699264 + offset * 256) / 256;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t;
    endfunction

    function void note_sample(logic [11:0] adc, logic [9:0] dt);
      thermo_result_t exp_r;
      logic [127:0] r, s;
      exp_r.rejected = (adc == 0 || adc == MAXCODE);
      exp_r.temp_valid = 1'b0;
      acc = (acc + dt) & 64'h1FFFF;
      if (!exp_r.rejected) begin
        r = ((128'(ref_ohms) * (MAXCODE - adc)) << 8) / adc;
        if (r > RES_MAX) r = RES_MAX;
        s = (128'(alpha) * r + 128'(65536 - alpha) * ema + 32768) >> 16;
        ema = s[63:0] & RES_MAX;
      end
      if (acc >= period) begin
        last_temp = temperature(ema);
        acc = 0;
        exp_r.temp_valid = 1'b1;
      end
      exp_r.resistance = ema[39:0];
      exp_r.tenths = last_temp[15:0];
      pending.push_back(exp_r);
    endfunction

    task check_result(logic [55:0] data, logic [1:0] user);
      thermo_result_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (data[39:0] != e.resistance) report("resistance", data[39:0], e.resistance);
      if (user[0] != e.rejected) report("rejected", user[0], e.rejected);
      if (user[1] != e.temp_valid) report("temp_valid", user[1], e.temp_valid);
      if (data[55:40] != e.tenths) report("tenths", data[55:40], e.tenths);
    endtask

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_index_i = 0;
  logic [47:0] cfg_data_i = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [23:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  thermo_scoreboard sb = new();
  int idle_cycles = 0;
  bit stall_free = 0;

  always #2 clk_i = ~clk_i;

  ntc_thermistor_temperature_top DUT (.*);

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_free) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) < 70) ? 1'b1 : (gap_len() == 0);
  end

  task automatic send_sample(logic [11:0] adc, logic [9:0] dt);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata <= {2'b00, dt, adc};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(adc, dt);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    cfg_index_i <= idx;
    cfg_data_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
    @(negedge clk_i);
  endtask

  function automatic logic [11:0] rand_adc();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5) return 12'd0;
    if (k < 10) return 12'd4095;
    if (k < 20) return 12'($urandom_range(1, 40));
    if (k < 30) return 12'($urandom_range(4050, 4094));
    return 12'($urandom_range(1, 4094));
  endfunction

  task automatic random_run(int n, int dt_max);
    for (int i = 0; i < n; i++) send_sample(rand_adc(), 10'($urandom_range(0, dt_max)));
  endtask

  initial begin
    sb.reset_state();
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    send_sample(12'd2048, 10'd0);
    send_sample(12'd0, 10'd1000);
    send_sample(12'd4095, 10'd0);
    send_sample(12'd1, 10'd1000);
    send_sample(12'd4094, 10'd1000);
    send_sample(12'd2048, 10'd999);
    send_sample(12'hAAA, 10'h155);
    send_sample(12'h555, 10'h2AA);
    drain();
    write_reg(CFG_PERIOD, 48'd1);
    write_reg(CFG_ALPHA, 48'd65535);
    write_reg(CFG_OFFSET, 48'h7FF & 11'sd1000);
    write_reg(CFG_REF, 48'd1000000);
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
    send_sample(12'd1, 10'd1);
    send_sample(12'd4094, 10'd0);
    send_sample(12'd100, 10'd5);
    send_sample(12'd0, 10'd1);
    drain();
    write_reg(CFG_COEF_A, 48'd0);
    write_reg(CFG_COEF_B, 48'd0);
    write_reg(CFG_COEF_C, 48'd0);
    write_reg(CFG_PERIOD, 48'd0);
    send_sample(12'd2000, 10'd0);
    drain();
    write_reg(CFG_COEF_A, 48'h7FFF_FFFF_FFFF);
    write_reg(CFG_COEF_B, 48'h8000_0000_0000);
    write_reg(CFG_COEF_C, 48'h7FFF_FFFF_FFFF);
    write_reg(CFG_OFFSET, 48'h7FF & -11'sd1000);
    write_reg(CFG_ALPHA, 48'd1);
    write_reg(CFG_REF, 48'd1);
    send_sample(12'd3000, 10'd3);
    send_sample(12'd7, 10'd3);
    drain();
    write_reg(CFG_COEF_A, 48'h8000_0000_0000);
    write_reg(CFG_COEF_B, 48'h7FFF_FFFF_FFFF);
    write_reg(CFG_COEF_C, 48'h8000_0000_0000);
    send_sample(12'd3000, 10'd3);
    drain();
    // Default coefficients, reporting every few words.
    write_reg(CFG_COEF_A, -48'sd21053833106);
    write_reg(CFG_COEF_B, 48'sd89363387260);
    write_reg(CFG_COEF_C, -48'sd46841719);
    write_reg(CFG_OFFSET, 48'd0);
    write_reg(CFG_ALPHA, 48'd6554);
    write_reg(CFG_REF, 48'd100000);
    write_reg(CFG_PERIOD, 48'd1000);
    random_run(400, 1023);
    drain();
    stall_free = 1;
    write_reg(CFG_ALPHA, 48'($urandom_range(1, 65535)));
    write_reg(CFG_REF, 48'($urandom_range(1, 1000000)));
    write_reg(CFG_OFFSET, 48'h7FF & $urandom_range(0, 2000) - 1000);
    write_reg(CFG_PERIOD, 48'($urandom_range(1, 3000)));
    random_run(400, 1023);
    drain();
    stall_free = 0;
    write_reg(CFG_ALPHA, 48'd65535);
    write_reg(CFG_PERIOD, 48'd60000);
    random_run(300, 1023);
    drain();
    write_reg(CFG_ALPHA, 48'd1);
    write_reg(CFG_REF, 48'd1000000);
    write_reg(CFG_PERIOD, 48'd1);
    random_run(300, 1023);
    drain();
    write_reg(CFG_ALPHA, 48'd30000);
    write_reg(CFG_REF, 48'd10000);
    write_reg(CFG_PERIOD, 48'd500);
    random_run(380, 1023);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_mul.sv
rtl/ntc_div.sv
rtl/ntc_thermistor_temperature_top.sv
tb/sv/ntc_thermistor_temperature_top_test.sv
